// ----- design/nmea_rmc_time_extractor_macros.svh -----
// Assertion macros for the NMEA RMC time extractor checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef NMEA_RMC_TIME_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_TIME_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define NRTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NRTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/nrte_pkg.sv -----
// Package for the NMEA RMC time extractor: item types, character codes, queue sizes.
// No dependencies.
package nrte_pkg;

	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH = 2;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_A_UP   = 8'h41;
	localparam logic [7:0] CH_F_UP   = 8'h46;
	localparam logic [7:0] CH_A_LO   = 8'h61;
	localparam logic [7:0] CH_F_LO   = 8'h66;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [2:0] TALKER_LEN  = 3'd6;
	localparam logic [2:0] TIME_LEN    = 3'd6;
	localparam logic [2:0] MIN_FIELDS  = 3'd3;
	localparam logic [2:0] SAT_MAX     = 3'd7;
	localparam logic [5:0] HOUR_WRAP   = 6'd24;
	localparam logic [6:0] MAX_UTC_HR  = 7'd23;
	localparam logic [4:0] ZONE_RESET  = 5'd8;
	localparam logic [8:0] HEX_OVER    = 9'd256;
	localparam logic [8:0] HEX_SHIFT_LIM = 9'd16;

	localparam int REG_ZONE  = 0;
	localparam int PADDR_W   = 2;
	localparam int PDATA_W   = 32;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_sentence;
	} in_item_t;

	typedef struct packed {
		logic       sentence_accepted;
		logic [4:0] hours_out;
		logic [6:0] minutes_out;
		logic [6:0] seconds_out;
	} out_item_t;

	// classified byte passed from front to back
	typedef struct packed {
		logic [7:0] char_byte;
		logic       last;
		logic       is_comma;
		logic       is_star;
		logic       is_a;
		logic       dec_ok;
		logic       hex_ok;
		logic [3:0] nib;
	} cls_t;

	function automatic logic [7:0] talker_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = CH_DOLLAR;
			3'd1: c = CH_G;
			3'd2: c = CH_P;
			3'd3: c = CH_R;
			3'd4: c = CH_M;
			3'd5: c = CH_C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- design/nrte_front.sv -----
// Front of the NMEA RMC time extractor: accepts bytes, classifies them, queues them.
// Depends on nrte_pkg.
module nrte_front import nrte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t sentence_byte,
	output logic     full,
	input  logic     cq_pop,
	output logic     cq_empty,
	output cls_t     cq_head
);

	cls_t             cls;
	cls_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   cnt_q;
	logic             wr_en;
	logic [7:0]       c;

	assign c = sentence_byte.char_byte;

	always_comb begin
		cls           = '0;
		cls.char_byte = c;
		cls.last      = sentence_byte.end_of_sentence;
		cls.is_comma  = (c == CH_COMMA);
		cls.is_star   = (c == CH_STAR);
		cls.is_a      = (c == CH_A_UP);
		cls.dec_ok    = (c >= CH_ZERO) && (c <= CH_NINE);
		priority if (cls.dec_ok) begin
			cls.hex_ok = 1'b1;
			cls.nib    = 4'(c - CH_ZERO);
		end else if (c >= CH_A_UP && c <= CH_F_UP) begin
			cls.hex_ok = 1'b1;
			cls.nib    = 4'(c - CH_A_UP + 8'd10);
		end else if (c >= CH_A_LO && c <= CH_F_LO) begin
			cls.hex_ok = 1'b1;
			cls.nib    = 4'(c - CH_A_LO + 8'd10);
		end else begin
			cls.hex_ok = 1'b0;
			cls.nib    = 4'd0;
		end
	end

	assign full     = (cnt_q == (CQ_AW+1)'(CQ_DEPTH));
	assign cq_empty = (cnt_q == '0);
	assign cq_head  = mem_q[rd_ptr_q];
	assign wr_en    = push && !full;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cq_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (CQ_AW+1)'(wr_en) - (CQ_AW+1)'(cq_pop);
		end
	end

endmodule

// ----- design/nrte_back.sv -----
// Back of the NMEA RMC time extractor: field parser, checksum, time update, result queue.
// Depends on nrte_pkg.
module nrte_back import nrte_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [4:0] zone,
	input  logic      cq_empty,
	input  cls_t      cq_head,
	output logic      cq_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t time_result
);

	logic [2:0] fidx_q, cif_q, n_fidx, n_cif;
	logic       ok_q, star_q, hexany_q, hexdone_q;
	logic       n_ok, n_star, n_hexany, n_hexdone;
	logic [7:0] xor_q, n_xor;
	logic [8:0] hexv_q, n_hexv;
	logic [6:0] td_q [3];
	logic [6:0] n_td [3];
	logic [4:0] held_h_q;
	logic [6:0] held_m_q, held_s_q;
	logic       first, verdict, take;
	logic [5:0] hsum;
	logic [4:0] hadj;
	logic [3:0] dec;
	logic [1:0] k;
	out_item_t  res;

	out_item_t        rmem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] rwr_q, rrd_q;
	logic [RQ_AW:0]   rcnt_q;
	logic             rq_full, rq_push;

	assign dec = cq_head.nib;
	assign k   = cif_q[2:1];

	always_comb begin
		n_fidx    = fidx_q;
		n_cif     = cif_q;
		n_ok      = ok_q;
		n_star    = star_q;
		n_hexany  = hexany_q;
		n_hexdone = hexdone_q;
		n_xor     = xor_q;
		n_hexv    = hexv_q;
		n_td      = td_q;
		first     = (fidx_q == '0) && (cif_q == '0);

		if (star_q) begin
			if (!hexdone_q) begin
				if (!cq_head.hex_ok) begin
					n_hexdone = 1'b1;
				end else begin
					n_hexany = 1'b1;
					n_hexv   = (hexv_q >= HEX_SHIFT_LIM) ? HEX_OVER : {1'b0, hexv_q[3:0], dec};
				end
			end
		end else if (cq_head.is_star) begin
			n_star = 1'b1;
		end else if (!first) begin
			n_xor = xor_q ^ cq_head.char_byte;
		end

		if (cq_head.is_comma) begin
			if (fidx_q == 3'd0 && cif_q != TALKER_LEN) n_ok = 1'b0;
			if (fidx_q == 3'd1 && cif_q < TIME_LEN) n_ok = 1'b0;
			if (fidx_q == 3'd2 && cif_q != 3'd1) n_ok = 1'b0;
			if (fidx_q != SAT_MAX) n_fidx = fidx_q + 3'd1;
			n_cif = '0;
		end else begin
			unique case (fidx_q)
				3'd0: begin
					if (cif_q >= TALKER_LEN || cq_head.char_byte != talker_char(cif_q)) n_ok = 1'b0;
				end
				3'd1: begin
					if (cif_q < TIME_LEN) begin
						if (!cq_head.dec_ok) begin
							n_ok = 1'b0;
						end else if (!cif_q[0]) begin
							n_td[k] = 7'({dec, 3'b000}) + 7'({dec, 1'b0});
						end else begin
							n_td[k] = td_q[k] + 7'(dec);
						end
					end
				end
				3'd2: begin
					if (cif_q != 3'd0 || !cq_head.is_a) n_ok = 1'b0;
				end
				default: ;
			endcase
			if (cif_q != SAT_MAX) n_cif = cif_q + 3'd1;
		end

		verdict = n_ok && (n_fidx >= MIN_FIELDS) && n_star && n_hexany &&
			(n_hexv == {1'b0, n_xor}) && (n_td[0] <= MAX_UTC_HR);

		hsum = {1'b0, n_td[0][4:0]} + {1'b0, zone};
		priority if (hsum > HOUR_WRAP) begin
			hadj = 5'(hsum - HOUR_WRAP);
		end else if (hsum == HOUR_WRAP && (n_td[1] != '0 || n_td[2] != '0)) begin
			hadj = '0;
		end else begin
			hadj = hsum[4:0];
		end

		res.sentence_accepted = verdict;
		res.hours_out         = verdict ? hadj : held_h_q;
		res.minutes_out       = verdict ? n_td[1] : held_m_q;
		res.seconds_out       = verdict ? n_td[2] : held_s_q;
	end

	assign rq_full = (rcnt_q == (RQ_AW+1)'(RQ_DEPTH));
	assign take    = !cq_empty && (!cq_head.last || !rq_full);
	assign cq_pop  = take;
	assign rq_push = take && cq_head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q    <= '0;
			cif_q     <= '0;
			ok_q      <= 1'b1;
			star_q    <= 1'b0;
			hexany_q  <= 1'b0;
			hexdone_q <= 1'b0;
			xor_q     <= '0;
			hexv_q    <= '0;
			td_q      <= '{default: '0};
			held_h_q  <= '0;
			held_m_q  <= '0;
			held_s_q  <= '0;
		end else if (take) begin
			if (cq_head.last) begin
				fidx_q    <= '0;
				cif_q     <= '0;
				ok_q      <= 1'b1;
				star_q    <= 1'b0;
				hexany_q  <= 1'b0;
				hexdone_q <= 1'b0;
				xor_q     <= '0;
				hexv_q    <= '0;
				td_q      <= '{default: '0};
				held_h_q  <= res.hours_out;
				held_m_q  <= res.minutes_out;
				held_s_q  <= res.seconds_out;
			end else begin
				fidx_q    <= n_fidx;
				cif_q     <= n_cif;
				ok_q      <= n_ok;
				star_q    <= n_star;
				hexany_q  <= n_hexany;
				hexdone_q <= n_hexdone;
				xor_q     <= n_xor;
				hexv_q    <= n_hexv;
				td_q      <= n_td;
			end
		end
	end

	// result queue
	assign empty       = (rcnt_q == '0);
	assign time_result = rmem_q[rrd_q];

	always_ff @(posedge clk) begin
		if (rq_push) begin
			rmem_q[rwr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwr_q  <= '0;
			rrd_q  <= '0;
			rcnt_q <= '0;
		end else begin
			if (rq_push) begin
				rwr_q <= rwr_q + 1'b1;
			end
			if (pop && !empty) begin
				rrd_q <= rrd_q + 1'b1;
			end
			rcnt_q <= rcnt_q + (RQ_AW+1)'(rq_push) - (RQ_AW+1)'(pop && !empty);
		end
	end

endmodule

// ----- design/nmea_rmc_time_extractor.sv -----
// Top level of the NMEA RMC time extractor: APB zone register, front and back.
// Depends on nrte_pkg, nrte_front, nrte_back.
//
//   channel   handshake           payload
//   bytes     push / full         sentence_byte (in_item_t)
//   results   pop / empty         time_result (out_item_t)
//   config    psel/penable/pready paddr, pwdata, prdata
//
// One byte per cycle unless the back stalls; bytes are queued before parsing.
// The 4-deep byte queue and 2-deep result queue let each side stall alone.
// The back stalls only on a last byte while the result queue is full.
// arst_n clears all control state; the zone offset resets to 8 hours.
module nmea_rmc_time_extractor import nrte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  in_item_t           sentence_byte,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output out_item_t          time_result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [4:0] zone_q;
	logic       cq_pop, cq_empty;
	cls_t       cq_head;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (32'(paddr >> 2) == 32'(REG_ZONE));
	assign prdata  = reg_sel ? PDATA_W'(zone_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			zone_q <= pwdata[4:0];
		end
	end

	nrte_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.sentence_byte (sentence_byte),
		.full          (full),
		.cq_pop        (cq_pop),
		.cq_empty      (cq_empty),
		.cq_head       (cq_head)
	);

	nrte_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.zone        (zone_q),
		.cq_empty    (cq_empty),
		.cq_head     (cq_head),
		.cq_pop      (cq_pop),
		.empty       (empty),
		.pop         (pop),
		.time_result (time_result)
	);

endmodule

// ----- design/nrte_checker.sv -----
// Port-level checker for the NMEA RMC time extractor, bound to the top level.
// Depends on nrte_pkg and nmea_rmc_time_extractor_macros.svh.
`include "nmea_rmc_time_extractor_macros.svh"

module nrte_checker import nrte_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t time_result
);

	logic       seen_q;
	logic [4:0] last_h_q;
	logic [6:0] last_m_q, last_s_q;
	logic       shown;

	assign shown = !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			last_h_q <= '0;
			last_m_q <= '0;
			last_s_q <= '0;
		end else if (shown && pop) begin
			seen_q   <= 1'b1;
			last_h_q <= time_result.hours_out;
			last_m_q <= time_result.minutes_out;
			last_s_q <= time_result.seconds_out;
		end
	end

	`NRTE_ASSERT_NEXT(a_hold_item, shown && !pop, shown && $stable(time_result), "result item changed while stalled")
	`NRTE_ASSERT_NOW(a_hour_range, shown, time_result.hours_out <= 5'd30, "hour out of range")
	`NRTE_ASSERT_NOW(a_first_reject, shown && !seen_q && !time_result.sentence_accepted, time_result.hours_out == '0 && time_result.minutes_out == '0 && time_result.seconds_out == '0, "first rejected item shows a nonzero time")
	`NRTE_ASSERT_NOW(a_reject_keeps, shown && seen_q && !time_result.sentence_accepted, time_result.hours_out == last_h_q && time_result.minutes_out == last_m_q && time_result.seconds_out == last_s_q, "rejected item changed held time")

endmodule

bind nmea_rmc_time_extractor nrte_checker u_nrte_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.time_result (time_result)
);
